// ===== rtl/lpff_pkg.sv =====
// Shared types, constants and tables of the laser potential-field force block.
package lpff_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int MAX_BEAMS  = 4096;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int CNT_W      = PT_AW + 1;
  localparam int RAM_AW     = PT_AW + 1;
  localparam int RANGE_W    = 16;
  localparam int IDX_W      = 12;
  localparam int ANG_W      = 16;
  localparam int SUM_W      = 40;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);
  localparam int CORDIC_N   = 16;
  localparam int CORDIC_IW  = $clog2(CORDIC_N);
  localparam int CS_W       = 18;
  localparam int Z_W        = 25;
  localparam int DIV_NW     = 56;
  localparam int DIV_DW     = 32;
  localparam int DIV_CW     = $clog2(DIV_NW);

  localparam logic [RANGE_W-1:0] RANGE_LO  = 16'd2048;  // 0.5 m
  localparam logic [RANGE_W-1:0] RANGE_HI  = 16'd4096;  // 1.0 m
  localparam logic [18:0]        NEAR_X5   = 19'd16384; // 5 * 0.8 m
  localparam logic signed [CS_W-1:0] CORDIC_X0 = 18'sd9949;

  typedef enum logic [3:0] {
    CFG_KP_X      = 4'd0,
    CFG_KP_Y      = 4'd1,
    CFG_KD_X      = 4'd2,
    CFG_KD_Y      = 4'd3,
    CFG_REST      = 4'd4,
    CFG_START_ANG = 4'd5,
    CFG_ANG_STEP  = 4'd6,
    CFG_FORCE_LIM = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] kp_x;
    logic [15:0] kp_y;
    logic [15:0] kd_x;
    logic [15:0] kd_y;
    logic [15:0] rest;
    logic [15:0] start_ang;
    logic [15:0] ang_step;
    logic [15:0] force_lim;
  } cfg_t;

  // One classified beam handed from the front to the back.
  typedef struct packed {
    logic [RANGE_W-1:0] range;
    logic [ANG_W-1:0]   angle;
    logic [PT_AW-1:0]   addr;
    logic               bank;
    logic               keep;
    logic               compute;
    logic               last;
    logic               emit;
    logic [CNT_W-1:0]   n;
  } beam_op_t;

  typedef enum logic [4:0] {
    B_IDLE, B_ISSUE, B_PREP, B_KP_X, B_KD_X, B_KP_Y, B_KD_Y, B_WAIT_CS,
    B_TERM_X, B_TERM_Y, B_LAST, B_DIV_X, B_DIV_Y,
    B_SQ_XH, B_SQ_XM, B_SQ_XL, B_SQ_YH, B_SQ_YM, B_SQ_YL,
    B_CMP, B_SQRT, B_SC_XH, B_SC_XL, B_SDIV_X, B_SC_YH, B_SC_YL, B_SDIV_Y,
    B_OUT
  } back_state_e;

  // atan(2^-i) in units of 2^22 per quarter turn
  function automatic logic signed [Z_W-1:0] cordic_atan(input logic [CORDIC_IW-1:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      4'd0:  v = 25'sd2097152;
      4'd1:  v = 25'sd1238021;
      4'd2:  v = 25'sd654136;
      4'd3:  v = 25'sd332050;
      4'd4:  v = 25'sd166669;
      4'd5:  v = 25'sd83416;
      4'd6:  v = 25'sd41718;
      4'd7:  v = 25'sd20860;
      4'd8:  v = 25'sd10430;
      4'd9:  v = 25'sd5215;
      4'd10: v = 25'sd2608;
      4'd11: v = 25'sd1304;
      4'd12: v = 25'sd652;
      4'd13: v = 25'sd326;
      4'd14: v = 25'sd163;
      default: v = 25'sd81;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/lpff_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lpff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lpff_front.sv =====
// Front end: accepts beats, windows ranges, tracks point counts and banks.
module lpff_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lpff_pkg::RANGE_W-1:0] in_beam_range,
  input  logic [lpff_pkg::IDX_W-1:0]   in_beam_index,
  input  logic                         in_last_beam,
  input  lpff_pkg::cfg_t               cfg_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output lpff_pkg::beam_op_t           q_op_o
);

  logic [lpff_pkg::CNT_W-1:0] cur_cnt_r, prev_cnt_r, cur_cnt_nxt, prev_cnt_nxt;
  logic                       primed_r, bank_r, primed_nxt, bank_nxt;
  logic                       accept, in_win, idx_ok, cnt_ok, near, keep, compute;
  logic [lpff_pkg::CNT_W-1:0] cnt_after;
  logic [27:0]                ang_prod;
  logic [18:0]                range_x5;

  assign in_ready = !q_full_i;
  assign accept   = in_valid && in_ready;

  assign in_win   = (in_beam_range >= lpff_pkg::RANGE_LO) &&
                    (in_beam_range <= lpff_pkg::RANGE_HI);
  assign idx_ok   = 32'(in_beam_index) < lpff_pkg::MAX_BEAMS;
  assign cnt_ok   = 32'(cur_cnt_r) < lpff_pkg::MAX_POINTS;
  assign range_x5 = 19'(in_beam_range) * 19'd5;
  assign near     = range_x5 < lpff_pkg::NEAR_X5;
  assign keep     = idx_ok && in_win && cnt_ok;
  assign compute  = keep && primed_r && (cur_cnt_r < prev_cnt_r) && near;
  assign cnt_after = cur_cnt_r + lpff_pkg::CNT_W'(keep);
  assign ang_prod = {16'd0, in_beam_index} * {12'd0, cfg_i.ang_step};

  always_comb begin
    q_op_o.range   = in_beam_range;
    q_op_o.angle   = cfg_i.start_ang + ang_prod[lpff_pkg::ANG_W-1:0];
    q_op_o.addr    = cur_cnt_r[lpff_pkg::PT_AW-1:0];
    q_op_o.bank    = bank_r;
    q_op_o.keep    = keep;
    q_op_o.compute = compute;
    q_op_o.last    = in_last_beam;
    q_op_o.emit    = in_last_beam && primed_r;
    q_op_o.n       = (cnt_after < prev_cnt_r) ? cnt_after : prev_cnt_r;
    q_push_o       = accept;

    cur_cnt_nxt  = cur_cnt_r;
    prev_cnt_nxt = prev_cnt_r;
    primed_nxt   = primed_r;
    bank_nxt     = bank_r;
    if (accept) begin
      if (in_last_beam) begin
        prev_cnt_nxt = cnt_after;
        cur_cnt_nxt  = '0;
        primed_nxt   = 1'b1;
        bank_nxt     = !bank_r;
      end else begin
        cur_cnt_nxt = cnt_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cnt_r  <= '0;
      prev_cnt_r <= '0;
      primed_r   <= 1'b0;
      bank_r     <= 1'b0;
    end else begin
      cur_cnt_r  <= cur_cnt_nxt;
      prev_cnt_r <= prev_cnt_nxt;
      primed_r   <= primed_nxt;
      bank_r     <= bank_nxt;
    end
  end

endmodule

// ===== rtl/lpff_queue.sv =====
// Short queue of classified beams between front and back.
module lpff_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  lpff_pkg::beam_op_t op_i,
  output logic               full_o,
  input  logic               pop_i,
  output lpff_pkg::beam_op_t op_o,
  output logic               empty_o
);

  lpff_pkg::beam_op_t          slot_r [lpff_pkg::Q_DEPTH];
  logic [lpff_pkg::Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [lpff_pkg::Q_CW-1:0]   cnt_r;

  assign full_o  = cnt_r == lpff_pkg::Q_CW'(lpff_pkg::Q_DEPTH);
  assign empty_o = cnt_r == '0;
  assign op_o    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wr_ptr_r] <= op_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + lpff_pkg::Q_CW'(push_i) - lpff_pkg::Q_CW'(pop_i);
    end
  end

endmodule

// ===== rtl/lpff_cordic.sv =====
// Iterative rotation CORDIC: cosine and sine of a binary angle, Q4.14.
module lpff_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start_i,
  input  logic [lpff_pkg::ANG_W-1:0]        angle_i,
  output logic                              valid_o,
  output logic signed [lpff_pkg::CS_W-1:0]  cos_o,
  output logic signed [lpff_pkg::CS_W-1:0]  sin_o
);

  logic signed [lpff_pkg::CS_W-1:0] x_r, y_r, dx, dy;
  logic signed [lpff_pkg::Z_W-1:0]  z_r;
  logic [1:0]                       quad_r;
  logic [lpff_pkg::CORDIC_IW-1:0]   iter_r;
  logic                             run_r, valid_r;

  assign dx      = y_r >>> iter_r;
  assign dy      = x_r >>> iter_r;
  assign valid_o = valid_r;

  always_comb begin
    unique case (quad_r)
      2'd0: begin cos_o = x_r;  sin_o = y_r;  end
      2'd1: begin cos_o = -y_r; sin_o = x_r;  end
      2'd2: begin cos_o = -x_r; sin_o = -y_r; end
      default: begin cos_o = y_r; sin_o = -x_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      valid_r <= 1'b0;
    end else if (start_i) begin
      x_r     <= lpff_pkg::CORDIC_X0;
      y_r     <= '0;
      z_r     <= $signed({3'b000, angle_i[13:0], 8'd0});
      quad_r  <= angle_i[15:14];
      iter_r  <= '0;
      run_r   <= 1'b1;
      valid_r <= 1'b0;
    end else if (run_r) begin
      if (!z_r[lpff_pkg::Z_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - lpff_pkg::cordic_atan(iter_r);
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + lpff_pkg::cordic_atan(iter_r);
      end
      iter_r <= iter_r + 1'b1;
      if (iter_r == lpff_pkg::CORDIC_IW'(lpff_pkg::CORDIC_N - 1)) begin
        run_r   <= 1'b0;
        valid_r <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lpff_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module lpff_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [lpff_pkg::DIV_NW-1:0] dividend_i,
  input  logic [lpff_pkg::DIV_DW-1:0] divisor_i,
  output logic                        done_o,
  output logic [lpff_pkg::DIV_NW-1:0] quotient_o
);

  logic [lpff_pkg::DIV_NW-1:0] quo_r;
  logic [lpff_pkg::DIV_DW-1:0] rem_r, dvs_r;
  logic [lpff_pkg::DIV_DW:0]   trial, diff;
  logic [lpff_pkg::DIV_CW-1:0] cnt_r;
  logic                        run_r, done_r;
  logic                        take;

  assign trial      = {rem_r, quo_r[lpff_pkg::DIV_NW-1]};
  assign diff       = trial - {1'b0, dvs_r};
  assign take       = trial >= {1'b0, dvs_r};
  assign done_o     = done_r;
  assign quotient_o = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        quo_r <= dividend_i;
        dvs_r <= divisor_i;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= take ? diff[lpff_pkg::DIV_DW-1:0] : trial[lpff_pkg::DIV_DW-1:0];
        quo_r <= {quo_r[lpff_pkg::DIV_NW-2:0], take};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == lpff_pkg::DIV_CW'(lpff_pkg::DIV_NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/lpff_back.sv =====
// Back end: range store, spring-damper terms, scan averaging and clamping.
module lpff_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lpff_pkg::cfg_t               cfg_i,
  input  lpff_pkg::beam_op_t           q_op_i,
  input  logic                         q_empty_i,
  output logic                         q_pop_o,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [15:0]                  out_force_x,
  output logic [15:0]                  out_force_y,
  output logic [lpff_pkg::CNT_W-1:0]   out_paired_points
);

  lpff_pkg::back_state_e state_r, state_nxt;
  lpff_pkg::beam_op_t    op_r;

  logic                          ram_we, ram_re;
  logic [lpff_pkg::RAM_AW-1:0]   ram_waddr, ram_raddr;
  logic [lpff_pkg::RANGE_W-1:0]  ram_rdata;

  logic                             cs_start, cs_valid;
  logic signed [lpff_pkg::CS_W-1:0] cs_cos, cs_sin;

  logic                         div_start, div_done;
  logic [lpff_pkg::DIV_NW-1:0]  div_dividend, div_quo;
  logic [lpff_pkg::DIV_DW-1:0]  div_divisor;

  logic signed [17:0]             spring_r;
  logic signed [16:0]             damp_r;
  logic signed [33:0]             acc_r, kp_prod, kd_prod;
  logic signed [34:0]             scx_r, scy_r, sc_diff, sc_sel;
  logic signed [52:0]             term_prod, term_sh;
  logic signed [lpff_pkg::CS_W-1:0] cs_sel;
  logic [15:0]                    kp_sel, kd_sel;
  logic signed [lpff_pkg::SUM_W-1:0] sum_x_r, sum_y_r;
  logic [lpff_pkg::SUM_W-1:0]     mag_x, mag_y, ax_r, ay_r;
  logic                           sx_neg_r, sy_neg_r;
  logic [19:0]                    m_a, m_b;
  logic [39:0]                    m_prod;
  logic [63:0]                    mag2_r, sq_v_r, sq_root_r, sq_bit_r, sq_trial;
  logic [4:0]                     sq_cnt_r;
  logic [31:0]                    lim_sq, m_r;
  logic [55:0]                    scale_r, scale_sum;
  logic [15:0]                    fx_r, fy_r;
  logic                           out_load;

  function automatic logic [15:0] sat_neg(input logic neg, input logic [55:0] mag);
    logic [15:0] v;
    if (neg) begin
      v = (mag > 56'd32767) ? 16'h7FFF : mag[15:0];
    end else begin
      v = (mag > 56'd32768) ? 16'h8000 : (~mag[15:0] + 16'd1);
    end
    return v;
  endfunction

  lpff_ram #(.WIDTH(lpff_pkg::RANGE_W), .DEPTH(2 * lpff_pkg::MAX_POINTS)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (op_r.range),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  lpff_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cs_start),
    .angle_i (op_r.angle),
    .valid_o (cs_valid),
    .cos_o   (cs_cos),
    .sin_o   (cs_sin)
  );

  lpff_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign ram_waddr = {op_r.bank, op_r.addr};
  assign ram_raddr = {!op_r.bank, op_r.addr};

  // one spring/damper multiplier pair shared between the axes
  assign kp_sel  = (state_r == lpff_pkg::B_KP_Y) ? cfg_i.kp_y : cfg_i.kp_x;
  assign kd_sel  = (state_r == lpff_pkg::B_KD_Y) ? cfg_i.kd_y : cfg_i.kd_x;
  assign kp_prod = $signed(kp_sel) * spring_r;
  assign kd_prod = $signed(kd_sel) * damp_r;
  assign sc_diff = acc_r - kd_prod;
  assign sc_sel  = (state_r == lpff_pkg::B_TERM_Y) ? scy_r : scx_r;
  assign cs_sel  = (state_r == lpff_pkg::B_TERM_Y) ? cs_sin : cs_cos;
  assign term_prod = sc_sel * cs_sel;
  assign term_sh   = term_prod >>> 22;

  assign mag_x  = sum_x_r[lpff_pkg::SUM_W-1] ? 40'(-sum_x_r) : 40'(sum_x_r);
  assign mag_y  = sum_y_r[lpff_pkg::SUM_W-1] ? 40'(-sum_y_r) : 40'(sum_y_r);
  assign lim_sq = {16'd0, cfg_i.force_lim} * {16'd0, cfg_i.force_lim};
  assign sq_trial  = sq_root_r + sq_bit_r;
  assign m_prod    = m_a * m_b;
  assign scale_sum = scale_r + {16'd0, m_prod};

  // shared 20x20 multiplier: squares (mod 2^64) and limit scaling
  always_comb begin
    unique case (state_r)
      lpff_pkg::B_SQ_XH: begin m_a = ax_r[39:20]; m_b = ax_r[39:20]; end
      lpff_pkg::B_SQ_XM: begin m_a = ax_r[39:20]; m_b = ax_r[19:0];  end
      lpff_pkg::B_SQ_XL: begin m_a = ax_r[19:0];  m_b = ax_r[19:0];  end
      lpff_pkg::B_SQ_YH: begin m_a = ay_r[39:20]; m_b = ay_r[39:20]; end
      lpff_pkg::B_SQ_YM: begin m_a = ay_r[39:20]; m_b = ay_r[19:0];  end
      lpff_pkg::B_SQ_YL: begin m_a = ay_r[19:0];  m_b = ay_r[19:0];  end
      lpff_pkg::B_SC_XH: begin m_a = ax_r[39:20]; m_b = {4'd0, cfg_i.force_lim}; end
      lpff_pkg::B_SC_XL: begin m_a = ax_r[19:0];  m_b = {4'd0, cfg_i.force_lim}; end
      lpff_pkg::B_SC_YH: begin m_a = ay_r[39:20]; m_b = {4'd0, cfg_i.force_lim}; end
      lpff_pkg::B_SC_YL: begin m_a = ay_r[19:0];  m_b = {4'd0, cfg_i.force_lim}; end
      default: begin m_a = '0; m_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    q_pop_o      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    cs_start     = 1'b0;
    div_start    = 1'b0;
    div_dividend = {16'd0, mag_x};
    div_divisor  = {21'd0, op_r.n};
    out_load     = 1'b0;
    unique case (state_r)
      lpff_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          state_nxt = lpff_pkg::B_ISSUE;
        end
      end
      lpff_pkg::B_ISSUE: begin
        ram_we    = op_r.keep;
        ram_re    = op_r.compute;
        cs_start  = op_r.compute;
        state_nxt = op_r.compute ? lpff_pkg::B_PREP : lpff_pkg::B_LAST;
      end
      lpff_pkg::B_PREP:  state_nxt = lpff_pkg::B_KP_X;
      lpff_pkg::B_KP_X:  state_nxt = lpff_pkg::B_KD_X;
      lpff_pkg::B_KD_X:  state_nxt = lpff_pkg::B_KP_Y;
      lpff_pkg::B_KP_Y:  state_nxt = lpff_pkg::B_KD_Y;
      lpff_pkg::B_KD_Y:  state_nxt = lpff_pkg::B_WAIT_CS;
      lpff_pkg::B_WAIT_CS: begin
        if (cs_valid) begin
          state_nxt = lpff_pkg::B_TERM_X;
        end
      end
      lpff_pkg::B_TERM_X: state_nxt = lpff_pkg::B_TERM_Y;
      lpff_pkg::B_TERM_Y: state_nxt = lpff_pkg::B_LAST;
      lpff_pkg::B_LAST: begin
        priority if (!op_r.last || !op_r.emit) begin
          state_nxt = lpff_pkg::B_IDLE;
        end else if (op_r.n == '0) begin
          state_nxt = lpff_pkg::B_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = lpff_pkg::B_DIV_X;
        end
      end
      lpff_pkg::B_DIV_X: begin
        div_dividend = {16'd0, mag_y};
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = lpff_pkg::B_DIV_Y;
        end
      end
      lpff_pkg::B_DIV_Y: begin
        if (div_done) begin
          state_nxt = lpff_pkg::B_SQ_XH;
        end
      end
      lpff_pkg::B_SQ_XH: state_nxt = lpff_pkg::B_SQ_XM;
      lpff_pkg::B_SQ_XM: state_nxt = lpff_pkg::B_SQ_XL;
      lpff_pkg::B_SQ_XL: state_nxt = lpff_pkg::B_SQ_YH;
      lpff_pkg::B_SQ_YH: state_nxt = lpff_pkg::B_SQ_YM;
      lpff_pkg::B_SQ_YM: state_nxt = lpff_pkg::B_SQ_YL;
      lpff_pkg::B_SQ_YL: state_nxt = lpff_pkg::B_CMP;
      lpff_pkg::B_CMP: begin
        state_nxt = (mag2_r <= {32'd0, lim_sq}) ? lpff_pkg::B_OUT : lpff_pkg::B_SQRT;
      end
      lpff_pkg::B_SQRT: begin
        if (sq_cnt_r == 5'd31) begin
          state_nxt = lpff_pkg::B_SC_XH;
        end
      end
      lpff_pkg::B_SC_XH: state_nxt = lpff_pkg::B_SC_XL;
      lpff_pkg::B_SC_XL: begin
        div_start    = 1'b1;
        div_dividend = scale_sum;
        div_divisor  = m_r;
        state_nxt    = lpff_pkg::B_SDIV_X;
      end
      lpff_pkg::B_SDIV_X: begin
        if (div_done) begin
          state_nxt = lpff_pkg::B_SC_YH;
        end
      end
      lpff_pkg::B_SC_YH: state_nxt = lpff_pkg::B_SC_YL;
      lpff_pkg::B_SC_YL: begin
        div_start    = 1'b1;
        div_dividend = scale_sum;
        div_divisor  = m_r;
        state_nxt    = lpff_pkg::B_SDIV_Y;
      end
      lpff_pkg::B_SDIV_Y: begin
        if (div_done) begin
          state_nxt = lpff_pkg::B_OUT;
        end
      end
      lpff_pkg::B_OUT: begin
        if (!out_valid || out_ready) begin
          out_load  = 1'b1;
          state_nxt = lpff_pkg::B_IDLE;
        end
      end
      default: state_nxt = lpff_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lpff_pkg::B_IDLE;
      out_valid <= 1'b0;
      sum_x_r   <= '0;
      sum_y_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        lpff_pkg::B_TERM_X: sum_x_r <= sum_x_r + term_sh[lpff_pkg::SUM_W-1:0];
        lpff_pkg::B_TERM_Y: sum_y_r <= sum_y_r + term_sh[lpff_pkg::SUM_W-1:0];
        lpff_pkg::B_LAST: begin
          if (op_r.last && !op_r.emit) begin
            sum_x_r <= '0;
            sum_y_r <= '0;
          end
        end
        lpff_pkg::B_OUT: begin
          if (out_load) begin
            sum_x_r <= '0;
            sum_y_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      op_r <= q_op_i;
    end
    if (out_load) begin
      out_force_x       <= fx_r;
      out_force_y       <= fy_r;
      out_paired_points <= op_r.n;
    end
    unique case (state_r)
      lpff_pkg::B_PREP: begin
        spring_r <= $signed({2'b00, cfg_i.rest}) - $signed({2'b00, op_r.range});
        damp_r   <= $signed({1'b0, op_r.range}) - $signed({1'b0, ram_rdata});
      end
      lpff_pkg::B_KP_X, lpff_pkg::B_KP_Y: acc_r <= kp_prod;
      lpff_pkg::B_KD_X: scx_r <= sc_diff;
      lpff_pkg::B_KD_Y: scy_r <= sc_diff;
      lpff_pkg::B_LAST: begin
        sx_neg_r <= sum_x_r[lpff_pkg::SUM_W-1];
        sy_neg_r <= sum_y_r[lpff_pkg::SUM_W-1];
        fx_r     <= '0;
        fy_r     <= '0;
      end
      lpff_pkg::B_DIV_X: begin
        if (div_done) begin
          ax_r <= div_quo[lpff_pkg::SUM_W-1:0];
        end
      end
      lpff_pkg::B_DIV_Y: begin
        if (div_done) begin
          ay_r <= div_quo[lpff_pkg::SUM_W-1:0];
        end
      end
      lpff_pkg::B_SQ_XH: mag2_r <= {m_prod[23:0], 40'd0};
      lpff_pkg::B_SQ_XM, lpff_pkg::B_SQ_YM: mag2_r <= mag2_r + {3'd0, m_prod, 21'd0};
      lpff_pkg::B_SQ_XL, lpff_pkg::B_SQ_YL: mag2_r <= mag2_r + {24'd0, m_prod};
      lpff_pkg::B_SQ_YH: mag2_r <= mag2_r + {m_prod[23:0], 40'd0};
      lpff_pkg::B_CMP: begin
        fx_r      <= sat_neg(sx_neg_r, {16'd0, ax_r});
        fy_r      <= sat_neg(sy_neg_r, {16'd0, ay_r});
        sq_v_r    <= mag2_r;
        sq_root_r <= '0;
        sq_bit_r  <= 64'd1 << 62;
        sq_cnt_r  <= '0;
      end
      lpff_pkg::B_SQRT: begin
        if (sq_v_r >= sq_trial) begin
          sq_v_r    <= sq_v_r - sq_trial;
          sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
        end else begin
          sq_root_r <= sq_root_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
        sq_cnt_r <= sq_cnt_r + 1'b1;
      end
      lpff_pkg::B_SC_XH: begin
        m_r     <= sq_root_r[31:0];
        scale_r <= {m_prod[35:0], 20'd0};
      end
      lpff_pkg::B_SC_YH: scale_r <= {m_prod[35:0], 20'd0};
      lpff_pkg::B_SDIV_X: begin
        if (div_done) begin
          fx_r <= sat_neg(sx_neg_r, div_quo);
        end
      end
      lpff_pkg::B_SDIV_Y: begin
        if (div_done) begin
          fy_r <= sat_neg(sy_neg_r, div_quo);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/laser_potential_field_force_top.sv =====
// Per-beam beat: a beam that adds a term waits on the 16-step CORDIC; other beams skip it.
// An emitting last beam then runs two divides, the squares and the compare, plus a 32-step
// square root and two more divides when the force is clamped; with no pairs it goes straight to output.
// Result beat is registered; the next beam is taken while it waits; a front queue of 4 beams
// keeps input flowing. Reset (synchronous, rst_n low): registers to defaults, counts and
// sums cleared, first scan only primes the range store; no clearing pass.
module laser_potential_field_force_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_beam_range,
  input  logic [11:0] in_beam_index,
  input  logic        in_last_beam,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_force_x,
  output logic [15:0] out_force_y,
  output logic [10:0] out_paired_points,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lpff_pkg::cfg_t     cfg_r;
  lpff_pkg::beam_op_t push_op, pop_op;
  logic               q_full, q_push, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_x      <= 16'd256;
      cfg_r.kp_y      <= 16'd256;
      cfg_r.kd_x      <= 16'd2560;
      cfg_r.kd_y      <= 16'd2560;
      cfg_r.rest      <= 16'd4096;
      cfg_r.start_ang <= 16'd0;
      cfg_r.ang_step  <= 16'd45;
      cfg_r.force_lim <= 16'd3277;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lpff_pkg::CFG_KP_X:      cfg_r.kp_x      <= cfg_data;
        lpff_pkg::CFG_KP_Y:      cfg_r.kp_y      <= cfg_data;
        lpff_pkg::CFG_KD_X:      cfg_r.kd_x      <= cfg_data;
        lpff_pkg::CFG_KD_Y:      cfg_r.kd_y      <= cfg_data;
        lpff_pkg::CFG_REST:      cfg_r.rest      <= cfg_data;
        lpff_pkg::CFG_START_ANG: cfg_r.start_ang <= cfg_data;
        lpff_pkg::CFG_ANG_STEP:  cfg_r.ang_step  <= cfg_data;
        lpff_pkg::CFG_FORCE_LIM: cfg_r.force_lim <= cfg_data;
        default: ;
      endcase
    end
  end

  lpff_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_beam_range (in_beam_range),
    .in_beam_index (in_beam_index),
    .in_last_beam  (in_last_beam),
    .cfg_i         (cfg_r),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_op_o        (push_op)
  );

  lpff_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .op_o    (pop_op),
    .empty_o (q_empty)
  );

  lpff_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_i             (cfg_r),
    .q_op_i            (pop_op),
    .q_empty_i         (q_empty),
    .q_pop_o           (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_force_x       (out_force_x),
    .out_force_y       (out_force_y),
    .out_paired_points (out_paired_points)
  );

endmodule
